@@ src/szb_pkg.sv @@
// package: item types, action codes, sprite geometry and the reciprocal table
package szb_pkg;

	localparam int SPRITE_SIDE = 64;
	localparam int COORD_SPAN  = 1024;
	localparam int SIDE_W      = $clog2(SPRITE_SIDE);
	localparam int ADDR_W      = 2 * SIDE_W;
	localparam int MAP_DEPTH   = 256;
	localparam int RECIP_W     = 20;
	localparam int RECIP_SHIFT = 19;
	localparam int PROD_W      = SIDE_W + RECIP_W;

	localparam logic [1:0] ACT_LOAD_SPRITE = 2'd0;
	localparam logic [1:0] ACT_LOAD_MAP    = 2'd1;
	localparam logic [1:0] ACT_DRAW        = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [11:0] load_index;
		logic [7:0]  load_value;
		logic [9:0]  dest_x;
		logic [9:0]  dest_y;
		logic [5:0]  zoom_x;
		logic [5:0]  zoom_y;
		logic [5:0]  row;
		logic        mirror_h;
		logic        mirror_v;
		logic        transparent;
	} in_item_t;

	typedef struct packed {
		logic [10:0] pixel_x;
		logic [10:0] pixel_y;
		logic [7:0]  pen;
		logic        write_enable;
		logic        last;
	} out_item_t;

	// request to the shared coordinate unit
	typedef struct packed {
		logic              en;
		logic [SIDE_W-1:0] pos;
		logic [SIDE_W-1:0] zoom;
		logic              mirror;
	} coord_req_t;

	typedef logic [RECIP_W-1:0] recip_tab_t [SPRITE_SIDE];

	// ceil(2^19 / (z+1)) for every zoom, by shift and subtract at elaboration
	function automatic recip_tab_t make_recip();
		recip_tab_t tab;
		int d;
		int rem;
		int quo;
		for (int z = 0; z < SPRITE_SIDE; z++) begin
			d   = z + 1;
			rem = 0;
			quo = 0;
			for (int b = RECIP_SHIFT; b >= 0; b--) begin
				rem = (rem << 1) | ((b == RECIP_SHIFT) ? 1 : 0);
				quo = quo << 1;
				if (rem >= d) begin
					rem = rem - d;
					quo = quo | 1;
				end
			end
			if (rem != 0) begin
				quo = quo + 1;
			end
			tab[z] = RECIP_W'(quo);
		end
		return tab;
	endfunction

endpackage

@@ src/szb_chan_if.sv @@
// valid/ready channel carrying one payload struct
interface szb_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/szb_coord.sv @@
// shared coordinate unit: floor(p*64/(zoom+1)) by reciprocal multiply, one per cycle
module szb_coord
	import szb_pkg::*;
(
	input  logic              clk,
	input  coord_req_t        req,
	output logic [SIDE_W-1:0] quot
);

	localparam recip_tab_t RECIP = make_recip();

	logic [SIDE_W-1:0] p;
	logic [PROD_W-1:0] prod_q;

	// mirrored position counts back from the far edge
	assign p = req.mirror ? (req.zoom - req.pos) : req.pos;

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= PROD_W'(p) * PROD_W'(RECIP[req.zoom]);
		end
	end

	// product carries 2^19/64 = 2^13 of scale
	assign quot = prod_q[RECIP_SHIFT-SIDE_W +: SIDE_W];

endmodule

@@ src/sprite_zoom_blitter_64.sv @@
// top level: zoomed sprite row blitter with sprite store and colour map
//
//  channel  dir  payload      request moves
//  in_if    in   in_item_t    one load or draw-row command
//  out_if   out  out_item_t   one destination pixel
//
// load requests are written in the accept cycle and leave the sequencer idle; a
// draw request is accepted, passes ST_ROW and ST_ROWW for the source row through
// the shared coordinate multiplier, issues zoom_x+1 columns in ST_COLS (one per
// cycle while out_if does not stall), then waits in ST_DRAIN while the sprite and
// colour map reads drain before the sequencer returns to idle
// a row beyond zoom_y or an unused action finishes in the accept cycle
// arst_n clears the sequencer and valid bits; both stores are undefined until written
// an out_if stall freezes the whole pixel pipeline; the next request is taken
// while the final pixel still waits in the output register
module sprite_zoom_blitter_64
	import szb_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	szb_chan_if.sink   in_if,
	szb_chan_if.source out_if
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ROW   = 3'd1;
	localparam logic [2:0] ST_ROWW  = 3'd2;
	localparam logic [2:0] ST_COLS  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;

	localparam logic [9:0] COORD_MASK = 10'(COORD_SPAN - 1);

	logic [2:0] state_q;

	// request fields held for the whole draw
	logic [9:0]        dest_x_q;
	logic [9:0]        dest_y_q;
	logic [5:0]        zoom_x_q;
	logic [5:0]        zoom_y_q;
	logic [5:0]        row_q;
	logic              mirror_h_q;
	logic              mirror_v_q;
	logic              transp_q;
	logic [SIDE_W-1:0] src_row_q;
	logic [5:0]        col_q;

	// pixel pipeline
	logic        v_s1, v_s2, out_valid_q;
	logic [5:0]  c_s1, c_s2;
	logic        last_s1, last_s2, last_q;
	logic [7:0]  b_s2;
	logic [7:0]  pen_q;
	logic        we_q;
	logic [10:0] px_q, py_q;

	// stores
	logic [7:0] sprite_mem [SPRITE_SIDE*SPRITE_SIDE];
	logic [7:0] cmap_mem [MAP_DEPTH];

	coord_req_t        creq;
	logic [SIDE_W-1:0] quot;
	logic              accept, adv, issue, draw_go;
	out_item_t         out_item;

	assign in_if.ready = (state_q == ST_IDLE);
	assign accept      = in_if.valid && in_if.ready;
	assign draw_go     = (in_if.data.action == ACT_DRAW) &&
	                     (in_if.data.row <= in_if.data.zoom_y);
	// whole pipeline moves unless the output register is stuck
	assign adv         = !out_valid_q || out_if.ready;
	assign issue       = (state_q == ST_COLS) && adv;

	// the multiplier serves the source row first, then one column a cycle while the output is not stalled
	always_comb begin
		creq.en     = (state_q == ST_ROW) || issue;
		creq.pos    = (state_q == ST_ROW) ? row_q : col_q;
		creq.zoom   = (state_q == ST_ROW) ? zoom_y_q : zoom_x_q;
		creq.mirror = (state_q == ST_ROW) ? mirror_v_q : mirror_h_q;
	end

	szb_coord u_coord (
		.clk  (clk),
		.req  (creq),
		.quot (quot)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && draw_go) begin
						state_q <= ST_ROW;
					end
				end
				ST_ROW: begin
					state_q <= ST_ROWW;
				end
				ST_ROWW: begin
					col_q   <= '0;
					state_q <= ST_COLS;
				end
				ST_COLS: begin
					if (adv) begin
						if (col_q == zoom_x_q) begin
							state_q <= ST_DRAIN;
						end else begin
							col_q <= col_q + 6'd1;
						end
					end
				end
				ST_DRAIN: begin
					// reads finished, a stalled last pixel may still wait
					if (!v_s1 && !v_s2) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// capture of request fields and source row
	always_ff @(posedge clk) begin
		if (accept) begin
			dest_x_q   <= in_if.data.dest_x & COORD_MASK;
			dest_y_q   <= in_if.data.dest_y & COORD_MASK;
			zoom_x_q   <= in_if.data.zoom_x;
			zoom_y_q   <= in_if.data.zoom_y;
			row_q      <= in_if.data.row;
			mirror_h_q <= in_if.data.mirror_h;
			mirror_v_q <= in_if.data.mirror_v;
			transp_q   <= in_if.data.transparent;
		end
		if (state_q == ST_ROWW) begin
			src_row_q <= quot;
		end
	end

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= issue;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1    <= col_q;
			last_s1 <= (col_q == zoom_x_q);
			c_s2    <= c_s1;
			last_s2 <= last_s1;
			last_q  <= last_s2;
			we_q    <= !(transp_q && (b_s2 == 8'd0));
			px_q    <= 11'(dest_x_q) + 11'(c_s2);
			py_q    <= 11'(dest_y_q) + 11'(row_q);
		end
	end

	// sprite store: load writes, one read per pixel
	always_ff @(posedge clk) begin
		if (accept && (in_if.data.action == ACT_LOAD_SPRITE)) begin
			sprite_mem[in_if.data.load_index] <= in_if.data.load_value;
		end
		if (adv) begin
			b_s2 <= sprite_mem[{src_row_q, quot}];
		end
	end

	// colour map: low 8 bits of the index
	always_ff @(posedge clk) begin
		if (accept && (in_if.data.action == ACT_LOAD_MAP)) begin
			cmap_mem[in_if.data.load_index[7:0]] <= in_if.data.load_value;
		end
		if (adv) begin
			pen_q <= cmap_mem[b_s2];
		end
	end

	// suppressed pixels report pen zero
	always_comb begin
		out_item.pixel_x      = px_q;
		out_item.pixel_y      = py_q;
		out_item.pen          = we_q ? pen_q : 8'd0;
		out_item.write_enable = we_q;
		out_item.last         = last_q;
	end

	assign out_if.valid = out_valid_q;
	assign out_if.data  = out_item;

	// pipeline is empty of reads whenever a new request can come in
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!v_s1 && !v_s2))
		else $error("reads in flight while idle");

	// final column in flight only once the issue loop has ended
	a_last_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && last_s1) |-> (state_q == ST_DRAIN))
		else $error("last column issued but sequencer still issuing");

	// column counter never runs past the row width
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COLS) |-> (col_q <= zoom_x_q))
		else $error("column counter beyond zoom_x");

	// a stalled output freezes the pipeline behind it
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_if.ready && (state_q == ST_COLS)) |=>
			((state_q == ST_COLS) && $stable(col_q)))
		else $error("column issued during output stall");

endmodule
